>>> hdl/lgd_pkg.sv
`default_nettype none
package lgd_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] BLANK_DIGIT = 8'd255;
  localparam logic [7:0] CMD_MODE    = 8'h02;
  localparam logic [7:0] CMD_DATA    = 8'h40;
  localparam logic [7:0] CMD_ADDR    = 8'hC0;
  localparam logic [7:0] CMD_DISP    = 8'h80;
  localparam logic [7:0] DISP_ON_BIT = 8'h08;
  localparam logic [7:0] COLON_SEGS  = 8'h03;
  localparam logic [7:0] ICON_LOW_BITS = 8'h0F;
  localparam logic [3:0] RAM_LAST    = 4'd13;
  localparam logic [3:0] RAM_PAIR0   = 4'd2;
  localparam logic [3:0] RAM_CLOSE_J = 4'd11;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [2:0] LEVEL_LIMIT = 3'd5;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h77, 8'h24, 8'h5D, 8'h6D, 8'h2E, 8'h6B, 8'h7B, 8'h25, 8'h7F, 8'h6F
  };

  localparam logic [2:0] BRIGHT_TABLE [5] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7};

  typedef enum logic [2:0] {
    OP_FRAME      = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_ENABLE     = 3'd2,
    OP_BRIGHTNESS = 3'd3,
    OP_INIT       = 3'd4,
    OP_DEINIT     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ARG   = 2'd1,
    ST_BAD_STATE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MODE,
    BK_RAM,
    BK_CTRL,
    BK_STATUS
  } phase_t;

  typedef struct packed {
    logic            has_mode;
    logic            has_ram;
    logic            has_ctrl;
    status_t         status;
    logic [7:0]      ctrl;
    logic [5:0][7:0] grid;
  } cmd_t;

  function automatic logic digit_ok(input logic [7:0] d);
    return (d == BLANK_DIGIT) || (d <= {4'd0, DIGIT_MAX});
  endfunction

  function automatic logic [7:0] seg_lookup(input logic [7:0] d);
    logic [7:0] s;
    s = 8'h00;
    if (d <= {4'd0, DIGIT_MAX}) begin
      s = SEG_TABLE[d[3:0]];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lgd_front.sv
`default_nettype none
module lgd_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [2:0]       in_operation,
  input  wire  [7:0]       in_digit_one,
  input  wire  [7:0]       in_digit_two,
  input  wire  [7:0]       in_digit_three,
  input  wire  [7:0]       in_digit_four,
  input  wire              in_colon_on,
  input  wire  [7:0]       in_icon_bits,
  input  wire              in_enable_flag,
  input  wire  [2:0]       in_brightness_level,
  input  wire              q_full,
  output logic             q_push,
  output lgd_pkg::cmd_t    q_data
);
  import lgd_pkg::*;

  logic       ready_r, ready_nxt;
  logic       disp_r, disp_nxt;
  logic [2:0] braw_r, braw_nxt;
  logic       digits_ok;
  logic       level_ok;
  logic [2:0] bright;
  cmd_t       cmd;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;
  assign digits_ok = digit_ok(in_digit_one) && digit_ok(in_digit_two) &&
                     digit_ok(in_digit_three) && digit_ok(in_digit_four);
  assign level_ok  = in_brightness_level < LEVEL_LIMIT;
  assign bright    = level_ok ? BRIGHT_TABLE[in_brightness_level] : 3'd0;

  always_comb begin
    ready_nxt     = ready_r;
    disp_nxt      = disp_r;
    braw_nxt      = braw_r;
    cmd.has_mode  = 1'b0;
    cmd.has_ram   = 1'b0;
    cmd.has_ctrl  = 1'b0;
    cmd.status    = ST_OK;
    cmd.ctrl      = 8'h00;
    cmd.grid      = '0;
    case (op_t'(in_operation))
      OP_FRAME: begin
        if (!ready_r) begin
          cmd.status = ST_BAD_STATE;
        end else if (!digits_ok) begin
          cmd.status = ST_BAD_ARG;
        end else begin
          cmd.has_ram = 1'b1;
          cmd.grid[0] = seg_lookup(in_digit_one);
          cmd.grid[1] = seg_lookup(in_digit_two);
          cmd.grid[2] = seg_lookup(in_digit_three);
          cmd.grid[3] = seg_lookup(in_digit_four);
          cmd.grid[4] = in_colon_on ? COLON_SEGS : 8'h00;
          cmd.grid[5] = in_icon_bits & ICON_LOW_BITS;
        end
      end
      OP_CLEAR: begin
        if (!ready_r) begin
          cmd.status = ST_BAD_STATE;
        end else begin
          cmd.has_ram = 1'b1;
        end
      end
      OP_ENABLE: begin
        if (!ready_r) begin
          cmd.status = ST_BAD_STATE;
        end else begin
          disp_nxt     = in_enable_flag;
          cmd.has_ctrl = 1'b1;
          cmd.ctrl     = CMD_DISP | {5'd0, braw_r} | (in_enable_flag ? DISP_ON_BIT : 8'h00);
        end
      end
      OP_BRIGHTNESS: begin
        if (!level_ok) begin
          cmd.status = ST_BAD_ARG;
        end else if (!ready_r) begin
          cmd.status = ST_BAD_STATE;
        end else begin
          braw_nxt     = bright;
          cmd.has_ctrl = 1'b1;
          cmd.ctrl     = CMD_DISP | {5'd0, bright} | (disp_r ? DISP_ON_BIT : 8'h00);
        end
      end
      OP_INIT: begin
        if (ready_r) begin
          cmd.status = ST_BAD_STATE;
        end else begin
          braw_nxt     = 3'd0;
          disp_nxt     = 1'b1;
          ready_nxt    = 1'b1;
          cmd.has_mode = 1'b1;
          cmd.has_ram  = 1'b1;
          cmd.has_ctrl = 1'b1;
          cmd.ctrl     = CMD_DISP | DISP_ON_BIT;
        end
      end
      OP_DEINIT: begin
        if (ready_r) begin
          disp_nxt     = 1'b0;
          braw_nxt     = 3'd0;
          ready_nxt    = 1'b0;
          cmd.has_ctrl = 1'b1;
          cmd.ctrl     = CMD_DISP | {5'd0, braw_r};
        end
      end
      default: begin
        cmd.status = ST_BAD_ARG;
      end
    endcase
  end

  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      disp_r  <= 1'b0;
      braw_r  <= 3'd0;
    end else if (q_push) begin
      ready_r <= ready_nxt;
      disp_r  <= disp_nxt;
      braw_r  <= braw_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/lgd_queue.sv
`default_nettype none
module lgd_queue #(
  parameter int DEPTH = lgd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  lgd_pkg::cmd_t    push_data,
  output logic             full,
  input  wire              pop,
  output logic             q_valid,
  output lgd_pkg::cmd_t    q_data
);
  import lgd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = count_r == CW'(DEPTH);
  assign q_valid = count_r != '0;
  assign q_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue pushed while full");
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

>>> hdl/lgd_back.sv
`default_nettype none
module lgd_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  input  lgd_pkg::cmd_t    q_data,
  output logic             pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic             out_is_status,
  output logic [7:0]       out_data_byte,
  output logic             out_strobe_open,
  output logic             out_strobe_close,
  output logic [1:0]       out_status_code,
  output logic             out_last_result
);
  import lgd_pkg::*;

  phase_t     state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] pair_j;
  logic       adv;
  logic       emit;
  logic       valid_r, valid_nxt;
  logic       is_status_r, is_status_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       open_r, open_nxt;
  logic       close_r, close_nxt;
  logic [1:0] code_r, code_nxt;
  logic       last_r, last_nxt;

  function automatic phase_t first_phase(input cmd_t c);
    phase_t p;
    if (c.has_mode) begin
      p = BK_MODE;
    end else if (c.has_ram) begin
      p = BK_RAM;
    end else if (c.has_ctrl) begin
      p = BK_CTRL;
    end else begin
      p = BK_STATUS;
    end
    return p;
  endfunction

  assign adv    = !valid_r || out_ready;
  assign pair_j = idx_r - RAM_PAIR0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = first_phase(q_data);
        end
      end
      BK_MODE: begin
        if (adv) begin
          state_nxt = cmd_r.has_ram ? BK_RAM : (cmd_r.has_ctrl ? BK_CTRL : BK_STATUS);
        end
      end
      BK_RAM: begin
        if (adv && idx_r == RAM_LAST) begin
          state_nxt = cmd_r.has_ctrl ? BK_CTRL : BK_STATUS;
        end
      end
      BK_CTRL: begin
        if (adv) begin
          state_nxt = BK_STATUS;
        end
      end
      BK_STATUS: begin
        if (adv) begin
          state_nxt = q_valid ? first_phase(q_data) : BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    emit          = 1'b0;
    idx_nxt       = idx_r;
    is_status_nxt = 1'b0;
    byte_nxt      = 8'h00;
    open_nxt      = 1'b0;
    close_nxt     = 1'b0;
    code_nxt      = ST_OK;
    last_nxt      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop     = q_valid;
        idx_nxt = '0;
      end
      BK_MODE: begin
        emit      = adv;
        byte_nxt  = CMD_MODE;
        open_nxt  = 1'b1;
        close_nxt = 1'b1;
      end
      BK_RAM: begin
        emit = adv;
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (idx_r == '0) begin
          byte_nxt  = CMD_DATA;
          open_nxt  = 1'b1;
          close_nxt = 1'b1;
        end else if (idx_r == 4'd1) begin
          byte_nxt = CMD_ADDR;
          open_nxt = 1'b1;
        end else begin
          byte_nxt  = pair_j[0] ? 8'h00 : cmd_r.grid[pair_j[3:1]];
          close_nxt = pair_j == RAM_CLOSE_J;
        end
      end
      BK_CTRL: begin
        emit      = adv;
        byte_nxt  = cmd_r.ctrl;
        open_nxt  = 1'b1;
        close_nxt = 1'b1;
      end
      BK_STATUS: begin
        emit          = adv;
        pop           = adv && q_valid;
        idx_nxt       = '0;
        is_status_nxt = 1'b1;
        code_nxt      = cmd_r.status;
        last_nxt      = 1'b1;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
    cmd_nxt   = pop ? q_data : cmd_r;
    valid_nxt = emit || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (emit) begin
      is_status_r <= is_status_nxt;
      byte_r      <= byte_nxt;
      open_r      <= open_nxt;
      close_r     <= close_nxt;
      code_r      <= code_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_is_status    = is_status_r;
  assign out_data_byte    = byte_r;
  assign out_strobe_open  = open_r;
  assign out_strobe_close = close_r;
  assign out_status_code  = code_r;
  assign out_last_result  = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_RAM |-> idx_r <= RAM_LAST)
    else $error("ram byte index past end");
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && is_status_r |-> last_r && byte_r == 8'h00 && !open_r && !close_r)
    else $error("status word carries byte fields");
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !is_status_r |-> !last_r && code_r == ST_OK)
    else $error("byte word carries status fields");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == BK_IDLE || state_r == BK_STATUS)
    else $error("command taken in mid sequence");

endmodule
`default_nettype wire

>>> hdl/led_grid_display_command_sequencer.sv
// Output: one word per cycle while out_ready does not hold the output; an operation
// emits 1 to 17 words (init 17, frame and clear 15, enable, brightness and active
// deinit 2, status-only 1).
// A command queue of QUEUE_DEPTH entries sits between decode and the word sequencer.
// Reset (rst_n low, synchronous) clears ready, display and brightness state,
// empties the queue and drops any pending output word.
`default_nettype none
module led_grid_display_command_sequencer #(
  parameter int QUEUE_DEPTH = lgd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [2:0] in_operation,
  input  wire  [7:0] in_digit_one,
  input  wire  [7:0] in_digit_two,
  input  wire  [7:0] in_digit_three,
  input  wire  [7:0] in_digit_four,
  input  wire        in_colon_on,
  input  wire  [7:0] in_icon_bits,
  input  wire        in_enable_flag,
  input  wire  [2:0] in_brightness_level,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       out_is_status,
  output logic [7:0] out_data_byte,
  output logic       out_strobe_open,
  output logic       out_strobe_close,
  output logic [1:0] out_status_code,
  output logic       out_last_result
);
  import lgd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_data;
  cmd_t head_data;

  lgd_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_digit_one        (in_digit_one),
    .in_digit_two        (in_digit_two),
    .in_digit_three      (in_digit_three),
    .in_digit_four       (in_digit_four),
    .in_colon_on         (in_colon_on),
    .in_icon_bits        (in_icon_bits),
    .in_enable_flag      (in_enable_flag),
    .in_brightness_level (in_brightness_level),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_data              (push_data)
  );

  lgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (head_data)
  );

  lgd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (head_data),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_status    (out_is_status),
    .out_data_byte    (out_data_byte),
    .out_strobe_open  (out_strobe_open),
    .out_strobe_close (out_strobe_close),
    .out_status_code  (out_status_code),
    .out_last_result  (out_last_result)
  );

endmodule
`default_nettype wire

>>> sim/tb_led_grid_display_command_sequencer.sv
`timescale 1ns / 1ps
module tb_led_grid_display_command_sequencer;
  import lgd_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_OPS = 200;
  localparam int CALM_TAIL = 30;
  localparam int LONG_HOLD_AT = 60;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] SEG_CODES [10] = '{
    8'h77, 8'h24, 8'h5D, 8'h6D, 8'h2E, 8'h6B, 8'h7B, 8'h25, 8'h7F, 8'h6F
  };
  localparam logic [2:0] LEVEL_RAW [5] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7};

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    logic [7:0] d4;
    logic       colon;
    logic [7:0] icon;
    logic       en;
    logic [2:0] lvl;
  } op_item_t;

  typedef struct packed {
    op_item_t item;
    logic     direct;
    status_t  code;
  } stim_row_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data;
    logic       open;
    logic       close;
    status_t    code;
    logic       last;
  } word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_operation = '0;
  logic [7:0] in_digit_one = '0;
  logic [7:0] in_digit_two = '0;
  logic [7:0] in_digit_three = '0;
  logic [7:0] in_digit_four = '0;
  logic       in_colon_on = 1'b0;
  logic [7:0] in_icon_bits = '0;
  logic       in_enable_flag = 1'b0;
  logic [2:0] in_brightness_level = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_status;
  logic [7:0] out_data_byte;
  logic       out_strobe_open;
  logic       out_strobe_close;
  logic [1:0] out_status_code;
  logic       out_last_result;

  word_t     owed_words [$];
  stim_row_t dir_rows [$];
  bit        inited = 1'b0;
  bit        lamp_on = 1'b0;
  logic [2:0] level_raw = '0;
  int        n_bad = 0;
  bit        quiet = 1'b0;
  bit        long_hold_req = 1'b0;
  bit        long_hold_done = 1'b0;
  int        tx_count = 0;
  bit        tx_bursty = 1'b0;

  led_grid_display_command_sequencer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_digit_one       (in_digit_one),
    .in_digit_two       (in_digit_two),
    .in_digit_three     (in_digit_three),
    .in_digit_four      (in_digit_four),
    .in_colon_on        (in_colon_on),
    .in_icon_bits       (in_icon_bits),
    .in_enable_flag     (in_enable_flag),
    .in_brightness_level(in_brightness_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_status      (out_is_status),
    .out_data_byte      (out_data_byte),
    .out_strobe_open    (out_strobe_open),
    .out_strobe_close   (out_strobe_close),
    .out_status_code    (out_status_code),
    .out_last_result    (out_last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic add_byte(input logic [7:0] b, input logic op_open, input logic op_close);
    word_t w;
    w.is_status = 1'b0;
    w.data = b;
    w.open = op_open;
    w.close = op_close;
    w.code = ST_OK;
    w.last = 1'b0;
    owed_words.push_back(w);
  endtask

  task automatic add_status(input status_t s);
    word_t w;
    w.is_status = 1'b1;
    w.data = 8'h00;
    w.open = 1'b0;
    w.close = 1'b0;
    w.code = s;
    w.last = 1'b1;
    owed_words.push_back(w);
  endtask

  task automatic add_ram(input logic [5:0][7:0] grid);
    int g;
    add_byte(CMD_DATA, 1'b1, 1'b1);
    add_byte(CMD_ADDR, 1'b1, 1'b0);
    for (g = 0; g < 6; g++) begin
      add_byte(grid[g], 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, g == 5);
    end
  endtask

  task automatic add_ctrl();
    logic [7:0] c;
    c = CMD_DISP | {5'd0, level_raw};
    if (lamp_on) begin
      c = c | DISP_ON_BIT;
    end
    add_byte(c, 1'b1, 1'b1);
  endtask

  task automatic sequence_op(input op_item_t it);
    logic [5:0][7:0] grid;
    logic [3:0][7:0] digs;
    bit bad;
    int i;
    grid = '0;
    bad = 1'b0;
    digs = {it.d4, it.d3, it.d2, it.d1};
    case (it.op)
      OP_FRAME: begin
        if (!inited) begin
          add_status(ST_BAD_STATE);
        end else begin
          for (i = 0; i < 4; i++) begin
            if (digs[i] == BLANK_DIGIT) begin
              grid[i] = 8'h00;
            end else if (digs[i] < 8'd10) begin
              grid[i] = SEG_CODES[digs[i]];
            end else begin
              bad = 1'b1;
            end
          end
          if (bad) begin
            add_status(ST_BAD_ARG);
          end else begin
            grid[4] = it.colon ? 8'h03 : 8'h00;
            grid[5] = {4'h0, it.icon[3:0]};
            add_ram(grid);
            add_status(ST_OK);
          end
        end
      end
      OP_CLEAR: begin
        if (!inited) begin
          add_status(ST_BAD_STATE);
        end else begin
          add_ram(grid);
          add_status(ST_OK);
        end
      end
      OP_ENABLE: begin
        if (!inited) begin
          add_status(ST_BAD_STATE);
        end else begin
          lamp_on = it.en;
          add_ctrl();
          add_status(ST_OK);
        end
      end
      OP_BRIGHTNESS: begin
        if (it.lvl >= 3'd5) begin
          add_status(ST_BAD_ARG);
        end else if (!inited) begin
          add_status(ST_BAD_STATE);
        end else begin
          level_raw = LEVEL_RAW[it.lvl];
          add_ctrl();
          add_status(ST_OK);
        end
      end
      OP_INIT: begin
        if (inited) begin
          add_status(ST_BAD_STATE);
        end else begin
          level_raw = 3'd0;
          lamp_on = 1'b1;
          add_byte(CMD_MODE, 1'b1, 1'b1);
          add_ram(grid);
          add_ctrl();
          inited = 1'b1;
          add_status(ST_OK);
        end
      end
      OP_DEINIT: begin
        if (inited) begin
          lamp_on = 1'b0;
          add_ctrl();
          level_raw = 3'd0;
          inited = 1'b0;
        end
        add_status(ST_OK);
      end
      default: begin
        add_status(ST_BAD_ARG);
      end
    endcase
  endtask

  function automatic stim_row_t mk(input logic [2:0] op, input logic [7:0] d1,
                                   input logic [7:0] d2, input logic [7:0] d3,
                                   input logic [7:0] d4, input logic colon,
                                   input logic [7:0] icon, input logic en,
                                   input logic [2:0] lvl, input logic direct,
                                   input status_t code);
    stim_row_t r;
    r.item.op = op;
    r.item.d1 = d1;
    r.item.d2 = d2;
    r.item.d3 = d3;
    r.item.d4 = d4;
    r.item.colon = colon;
    r.item.icon = icon;
    r.item.en = en;
    r.item.lvl = lvl;
    r.direct = direct;
    r.code = code;
    return r;
  endfunction

  function automatic logic [7:0] roll_digit();
    logic [7:0] d;
    if ($urandom_range(0, 4) == 0) begin
      d = BLANK_DIGIT;
    end else begin
      d = 8'($urandom_range(0, 9));
    end
    return d;
  endfunction

  function automatic op_item_t roll_item();
    op_item_t it;
    int r;
    it.d1 = roll_digit();
    it.d2 = roll_digit();
    it.d3 = roll_digit();
    it.d4 = roll_digit();
    it.colon = 1'($urandom_range(0, 1));
    it.icon = 8'($urandom_range(0, 255));
    it.en = 1'($urandom_range(0, 1));
    it.lvl = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
    r = $urandom_range(0, 99);
    if (!inited && r < 70) begin
      it.op = OP_INIT;
    end else if (r < 35) begin
      it.op = OP_FRAME;
    end else if (r < 45) begin
      it.op = OP_CLEAR;
    end else if (r < 57) begin
      it.op = OP_ENABLE;
    end else if (r < 72) begin
      it.op = OP_BRIGHTNESS;
    end else if (r < 80) begin
      it.op = OP_INIT;
    end else if (r < 88) begin
      it.op = OP_DEINIT;
    end else if (r < 92) begin
      it.op = ($urandom_range(0, 1) == 1) ? OP_SPARE_HI : OP_SPARE_LO;
    end else begin
      it.op = 3'($urandom_range(0, 7));
    end
    if (it.op == OP_FRAME && $urandom_range(0, 4) == 0) begin
      it.d1 = 8'($urandom_range(0, 255));
      it.d2 = 8'($urandom_range(0, 255));
      it.d3 = 8'($urandom_range(0, 255));
      it.d4 = 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // call at a rising edge; returns at the edge where the word is taken
  task automatic offer(input op_item_t it);
    if (tx_count % 16 == 0) begin
      tx_bursty = ($urandom_range(0, 1) == 1);
    end
    tx_count++;
    if (!quiet && tx_bursty && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= it.op;
    in_digit_one <= it.d1;
    in_digit_two <= it.d2;
    in_digit_three <= it.d3;
    in_digit_four <= it.d4;
    in_colon_on <= it.colon;
    in_icon_bits <= it.icon;
    in_enable_flag <= it.en;
    in_brightness_level <= it.lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin : rx_side
    int stall;
    int tick;
    bit bursty;
    stall = 0;
    tick = 0;
    bursty = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) begin
        bursty = ($urandom_range(0, 1) == 1);
      end
      if (long_hold_req && !long_hold_done) begin
        stall = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && bursty && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (owed_words.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS) begin
          $display("unexpected word: status=%0b byte=%02h open=%0b close=%0b code=%0d last=%0b",
                   out_is_status, out_data_byte, out_strobe_open, out_strobe_close,
                   out_status_code, out_last_result);
        end
      end else begin
        w = owed_words.pop_front();
        if (w.is_status != out_is_status || w.data != out_data_byte ||
            w.open != out_strobe_open || w.close != out_strobe_close ||
            w.code != out_status_code || w.last != out_last_result) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) begin
            $display("word mismatch: exp status=%0b byte=%02h open=%0b close=%0b code=%0d last=%0b",
                     w.is_status, w.data, w.open, w.close, w.code, w.last);
            $display("               got status=%0b byte=%02h open=%0b close=%0b code=%0d last=%0b",
                     out_is_status, out_data_byte, out_strobe_open, out_strobe_close,
                     out_status_code, out_last_result);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int k;
    op_item_t it;
    dir_rows.push_back(mk(OP_FRAME, 8'd1, 8'd2, 8'd3, 8'd4, 1, 8'hFF, 1, 3'd0, 1, ST_BAD_STATE));
    dir_rows.push_back(mk(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 1, ST_BAD_STATE));
    dir_rows.push_back(mk(OP_ENABLE, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 1, 3'd0, 1, ST_BAD_STATE));
    dir_rows.push_back(mk(OP_BRIGHTNESS, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd7, 1, ST_BAD_ARG));
    dir_rows.push_back(mk(OP_BRIGHTNESS, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd2, 1,
                          ST_BAD_STATE));
    dir_rows.push_back(mk(OP_DEINIT, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 1, ST_OK));
    dir_rows.push_back(mk(OP_SPARE_LO, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 1, ST_BAD_ARG));
    dir_rows.push_back(mk(OP_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 8'hFF, 1, 3'd7, 1,
                          ST_BAD_ARG));
    dir_rows.push_back(mk(OP_INIT, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_INIT, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 1, ST_BAD_STATE));
    dir_rows.push_back(mk(OP_FRAME, 8'd0, 8'd9, BLANK_DIGIT, 8'd5, 1, 8'hFF, 0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_FRAME, 8'd1, 8'd2, 8'd3, 8'd10, 1, 8'h00, 0, 3'd0, 1, ST_BAD_ARG));
    dir_rows.push_back(mk(OP_FRAME, 8'd254, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 1, ST_BAD_ARG));
    dir_rows.push_back(mk(OP_FRAME, BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, 0, 8'h00,
                          0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_FRAME, 8'd8, 8'd8, 8'd8, 8'd8, 1, 8'h0F, 0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_FRAME, 8'd7, 8'd6, 8'd4, 8'd3, 0, 8'hF0, 0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_ENABLE, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_ENABLE, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 1, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_BRIGHTNESS, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_BRIGHTNESS, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd4, 0, ST_OK));
    dir_rows.push_back(mk(OP_BRIGHTNESS, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd5, 1, ST_BAD_ARG));
    dir_rows.push_back(mk(OP_BRIGHTNESS, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd1, 0, ST_OK));
    dir_rows.push_back(mk(OP_DEINIT, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 0, ST_OK));
    dir_rows.push_back(mk(OP_DEINIT, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 1, ST_OK));
    dir_rows.push_back(mk(OP_INIT, 8'd0, 8'd0, 8'd0, 8'd0, 0, 8'h00, 0, 3'd0, 0, ST_OK));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].item);
      if (dir_rows[i].direct) begin
        add_status(dir_rows[i].code);
      end else begin
        sequence_op(dir_rows[i].item);
      end
    end

    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k == LONG_HOLD_AT) begin
        long_hold_req = 1'b1;
      end
      if (k == RANDOM_OPS - CALM_TAIL) begin
        quiet = 1'b1;
      end
      it = roll_item();
      offer(it);
      sequence_op(it);
    end
    in_valid <= 1'b0;

    while (owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
